/* hw/rtl/acs_pkg.sv */
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, constants and byte classifiers for the CSI escape stripper.
// ----------------------------------------------------------------------------
package acs_pkg;

    // parameter byte store
    localparam int PARAM_DEPTH = 16;
    localparam int PTR_W       = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam int CNT_W       = $clog2(PARAM_DEPTH + 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ESC_CHAR  = 8'h1b;
    localparam logic [7:0] LBRACKET  = 8'h5b;
    localparam logic [7:0] SEMICOLON = 8'h3b;
    localparam logic [7:0] DIGIT_LO  = 8'h30;
    localparam logic [7:0] DIGIT_HI  = 8'h39;
    localparam logic [7:0] UPPER_LO  = 8'h41;
    localparam logic [7:0] UPPER_HI  = 8'h5a;
    localparam logic [7:0] LOWER_LO  = 8'h61;
    localparam logic [7:0] LOWER_HI  = 8'h7a;

    // what the back end replays before the command's own byte
    typedef enum logic [1:0] {
        FLUSH_NONE = 2'b00,
        FLUSH_ESC  = 2'b01,
        FLUSH_CSI  = 2'b10
    } flush_t;

    // one command per accepted input beat
    typedef struct packed {
        logic        store;     // append data to the parameter store
        logic        clear;     // drop the held parameters
        flush_t      flush;     // replay held bytes
        logic        emit;      // then emit data (or an empty end marker)
        logic        has_byte;  // 0: empty end marker
        logic [7:0]  data;
        logic        last;      // final beat of the text
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic is_param(input logic [7:0] b);
        is_param = ((b >= DIGIT_LO) && (b <= DIGIT_HI)) || (b == SEMICOLON);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        is_letter = ((b >= UPPER_LO) && (b <= UPPER_HI)) ||
                    ((b >= LOWER_LO) && (b <= LOWER_HI));
    endfunction

endpackage

/* hw/rtl/ansi_csi_escape_stripper_core.sv */
// ----------------------------------------------------------------------------
// ansi_csi_escape_stripper_core
// Strips ANSI CSI sequences (ESC '[' digits/semicolons letter) from a byte
// stream; aborted sequences are replayed verbatim.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata          tlast      tuser
//  -------  ---  -------------  ---------  ----------------------------
//  s_*      in   [7:0] in_byte  last_byte  -
//  m_*      out  [7:0] out_byte run_last   [0] has_byte, [1] text_end
//
//  Flow: the front takes one beat per cycle while the command queue has room.
//  The back emits at most one result per cycle and holds while the output
//  is stalled; a replay gives ESC '[' and then the n held parameters, then
//  the trailing byte if the command has one, and a lone ESC replay gives
//  ESC and then the trailing byte if there is one.
//  Reset clears the scan mode, counts, queue and output valid; the parameter
//  store holds garbage until written. Output stalls back up through the
//  queue to s_tready without losing beats.
// ----------------------------------------------------------------------------
module ansi_csi_escape_stripper_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // run_last
    output logic [1:0]  m_tuser     // [0] has_byte, [1] text_end
);

    acs_pkg::cmd_t   push_cmd;
    acs_pkg::cmd_t   pop_cmd;
    acs_pkg::qstat_t q_stat;
    logic            push;
    logic            pop;

    // classifier: scan mode and held count, one command per beat
    acs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    acs_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    // sequencer: parameter store, replay and output register
    acs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // an empty end marker is always the closing beat of the text
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && (m_tdata == 8'h00)))
        else $error("empty marker not flagged as end of text");

    // end of text only on the last result of its beat
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("text_end without run_last");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command queue overflow");

    // nothing is popped from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command queue underflow");

endmodule

/* hw/rtl/acs_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// acs_cmd_fifo
// Small command queue decoupling the classifier from the output sequencer.
// ----------------------------------------------------------------------------
module acs_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  acs_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output acs_pkg::cmd_t   pop_cmd,
    output acs_pkg::qstat_t stat
);

    acs_pkg::cmd_t                     slot_reg [acs_pkg::QUEUE_DEPTH];
    logic [acs_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [acs_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [acs_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign stat.full  = (cnt_reg == acs_pkg::QCNT_W'(acs_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/acs_front.sv */
// ----------------------------------------------------------------------------
// acs_front
// Accepts input beats, tracks the escape scan mode and issues one command
// per beat.
// ----------------------------------------------------------------------------
module acs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // [7:0] in_byte
    input  logic            s_tlast,    // last_byte
    input  acs_pkg::qstat_t q_stat,
    output logic            push,
    output acs_pkg::cmd_t   push_cmd
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_ESC  = 3'b010,
        MODE_CSI  = 3'b100
    } mode_t;

    mode_t                      mode_reg, mode_next;
    logic [acs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       b_esc, b_lb, b_par, b_let, full;
    acs_pkg::cmd_t              cmd;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;
    assign push_cmd = cmd;

    assign b_esc = (s_tdata == acs_pkg::ESC_CHAR);
    assign b_lb  = (s_tdata == acs_pkg::LBRACKET);
    assign b_par = acs_pkg::is_param(s_tdata);
    assign b_let = acs_pkg::is_letter(s_tdata);
    assign full  = (cnt_reg == acs_pkg::CNT_W'(acs_pkg::PARAM_DEPTH));

    always_comb
    begin
        cmd          = '0;
        cmd.flush    = acs_pkg::FLUSH_NONE;
        cmd.has_byte = 1'b1;
        cmd.data     = s_tdata;
        cmd.last     = s_tlast;
        // plain idle handling: an ESC is held unless the text ends here
        cmd.emit     = !b_esc || s_tlast;
        mode_next    = (b_esc && !s_tlast) ? MODE_ESC : MODE_IDLE;
        cnt_next     = '0;
        case (mode_reg)
            MODE_ESC:
            begin
                if (b_lb)
                begin
                    cmd.emit  = 1'b0;
                    cmd.flush = s_tlast ? acs_pkg::FLUSH_CSI : acs_pkg::FLUSH_NONE;
                    mode_next = s_tlast ? MODE_IDLE : MODE_CSI;
                end
                else
                begin
                    cmd.flush = acs_pkg::FLUSH_ESC;
                end
            end
            MODE_CSI:
            begin
                if (b_par && !full)
                begin
                    cmd.store = 1'b1;
                    cmd.emit  = 1'b0;
                    if (s_tlast)
                    begin
                        cmd.flush = acs_pkg::FLUSH_CSI;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = MODE_CSI;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                else if (b_par)
                begin
                    // store overflow: give the whole sequence back
                    cmd.flush = acs_pkg::FLUSH_CSI;
                    cmd.emit  = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else if (b_let)
                begin
                    cmd.clear    = 1'b1;
                    cmd.emit     = s_tlast;     // empty end marker
                    cmd.has_byte = 1'b0;
                    cmd.data     = '0;
                    mode_next    = MODE_IDLE;
                end
                else
                begin
                    cmd.flush = acs_pkg::FLUSH_CSI;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
        end
        else if (push)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* hw/rtl/acs_back.sv */
// ----------------------------------------------------------------------------
// acs_back
// Executes queued commands: keeps the parameter store, replays held bytes
// and drives the output register.
// ----------------------------------------------------------------------------
module acs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  acs_pkg::cmd_t   pop_cmd,
    input  acs_pkg::qstat_t q_stat,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tlast,    // run_last
    output logic [1:0]      m_tuser     // [0] has_byte, [1] text_end
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_ESC   = 5'b00010,
        ST_BRKT  = 5'b00100,
        ST_PARAM = 5'b01000,
        ST_BYTE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next, disp_state;
    acs_pkg::cmd_t              cmd_reg, cmd_next;
    logic [acs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [acs_pkg::PTR_W-1:0]  ptr_reg, ptr_next;
    logic [7:0]                 mem [acs_pkg::PARAM_DEPTH];
    logic [7:0]                 rd_data_reg;
    logic                       out_ok, emit, more, last_param;
    logic [7:0]                 emit_byte;
    logic                       emit_has;
    logic                       ovalid_reg;
    logic [7:0]                 obyte_reg;
    logic                       olast_reg, ohas_reg, oend_reg;

    assign out_ok     = !ovalid_reg || m_tready;
    assign last_param = (acs_pkg::CNT_W'(ptr_reg) == cnt_reg - acs_pkg::CNT_W'(1));

    // next state for a freshly popped command
    always_comb
    begin
        if (pop_cmd.flush != acs_pkg::FLUSH_NONE)
        begin
            disp_state = ST_ESC;
        end
        else if (pop_cmd.emit)
        begin
            disp_state = ST_BYTE;
        end
        else
        begin
            disp_state = ST_LOAD;
        end
    end

    always_comb
    begin
        emit       = 1'b0;
        more       = 1'b0;
        emit_byte  = cmd_reg.data;
        emit_has   = 1'b1;
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        ptr_next   = '0;
        pop        = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                pop = !q_stat.empty;
            end
            ST_ESC:
            begin
                emit      = out_ok;
                emit_byte = acs_pkg::ESC_CHAR;
                more      = (cmd_reg.flush == acs_pkg::FLUSH_CSI) || cmd_reg.emit;
                if (emit)
                begin
                    if (cmd_reg.flush == acs_pkg::FLUSH_CSI)
                    begin
                        state_next = ST_BRKT;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = cmd_reg.emit ? ST_BYTE : ST_LOAD;
                    end
                end
            end
            ST_BRKT:
            begin
                emit      = out_ok;
                emit_byte = acs_pkg::LBRACKET;
                more      = (cnt_reg != '0) || cmd_reg.emit;
                if (emit)
                begin
                    if (cnt_reg != '0)
                    begin
                        state_next = ST_PARAM;
                    end
                    else
                    begin
                        state_next = cmd_reg.emit ? ST_BYTE : ST_LOAD;
                    end
                end
            end
            ST_PARAM:
            begin
                emit      = out_ok;
                emit_byte = rd_data_reg;
                more      = !last_param || cmd_reg.emit;
                ptr_next  = ptr_reg;
                if (emit)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    if (last_param)
                    begin
                        cnt_next   = '0;
                        state_next = cmd_reg.emit ? ST_BYTE : ST_LOAD;
                    end
                end
            end
            ST_BYTE:
            begin
                emit     = out_ok;
                emit_has = cmd_reg.has_byte;
                more     = 1'b0;
                if (emit)
                begin
                    state_next = ST_LOAD;
                    pop        = !q_stat.empty;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (pop)
        begin
            cmd_next   = pop_cmd;
            state_next = disp_state;
            if (pop_cmd.store)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (pop_cmd.clear)
            begin
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            obyte_reg <= emit_byte;
            ohas_reg  <= emit_has;
            olast_reg <= !more;
            oend_reg  <= !more && cmd_reg.last;
        end
    end

    // parameter store, registered read
    always_ff @(posedge clk)
    begin
        if (pop && pop_cmd.store)
        begin
            mem[cnt_reg[acs_pkg::PTR_W-1:0]] <= pop_cmd.data;
        end
        rd_data_reg <= mem[ptr_next];
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = {oend_reg, ohas_reg};

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the CSI escape stripper: directed escape corner cases,
// then random text and escape traffic under random source gaps and sink
// stalls, then gap-free source traffic. Every output beat is checked against
// a cycle-free software model of the stripper.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;        // 12 ns clock
    localparam int CYCLE_LIMIT  = 2000000;  // hard stop, far above a slow run
    localparam int DRAIN_CYCLES = 64;       // quiet time after the last result

    // scan state of the software model
    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_ESC  = 2'd1,
        SCAN_CSI  = 2'd2
    } scan_t;

    // what a byte means while inside "ESC ["
    typedef enum logic [1:0] {
        CLS_PARAM = 2'd0,   // digit or semicolon
        CLS_FINAL = 2'd1,   // ASCII letter, ends the sequence
        CLS_OTHER = 2'd2    // anything else aborts it
    } byte_class_t;

    // shape of one random chunk of traffic
    typedef enum logic [2:0] {
        CHUNK_CSI      = 3'd0,
        CHUNK_ABORT    = 3'd1,
        CHUNK_LONE_ESC = 3'd2,
        CHUNK_OVERFLOW = 3'd3,
        CHUNK_PLAIN    = 3'd4
    } chunk_t;

    // one output beat as the model sees it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
    } out_beat_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tlast;            // run_last
    logic [1:0] m_tuser;            // [0] has_byte, [1] text_end

    ansi_csi_escape_stripper_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin : clock_gen
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model state and bookkeeping
    // ------------------------------------------------------------------------
    scan_t       scan_state = SCAN_IDLE;
    logic [7:0]  held_buf [acs_pkg::PARAM_DEPTH];
    int          held_cnt   = 0;

    out_beat_t   beat_out[$];           // results of the beat being modeled
    out_beat_t   pending_out_q[$];      // results still owed by the DUT

    int          mismatches      = 0;
    int          beats_sent      = 0;
    int          results_seen    = 0;
    int          texts_closed    = 0;
    int          csi_stripped    = 0;
    int          store_overflows = 0;
    int unsigned cycle_count     = 0;

    bit          src_steady  = 1'b0;    // no gaps between source beats
    bit          sink_steady = 1'b0;    // sink never stalls

    // ------------------------------------------------------------------------
    // Stripper model
    // ------------------------------------------------------------------------
    function automatic byte_class_t classify(input logic [7:0] b);
        if ((b >= acs_pkg::DIGIT_LO && b <= acs_pkg::DIGIT_HI) || b == acs_pkg::SEMICOLON)
            return CLS_PARAM;
        if ((b >= acs_pkg::UPPER_LO && b <= acs_pkg::UPPER_HI) ||
            (b >= acs_pkg::LOWER_LO && b <= acs_pkg::LOWER_HI))
            return CLS_FINAL;
        return CLS_OTHER;
    endfunction

    function automatic void put_out(input logic [7:0] b);
        beat_out.push_back({b, 1'b1, 1'b0, 1'b0});
    endfunction

    // give back whatever escape prefix is held, verbatim
    function automatic void replay_held();
        if (scan_state == SCAN_ESC)
        begin
            put_out(acs_pkg::ESC_CHAR);
        end
        else if (scan_state == SCAN_CSI)
        begin
            put_out(acs_pkg::ESC_CHAR);
            put_out(acs_pkg::LBRACKET);
            for (int k = 0; k < held_cnt; k++)
                put_out(held_buf[k]);
        end
        scan_state = SCAN_IDLE;
        held_cnt   = 0;
    endfunction

    function automatic void take_plain(input logic [7:0] b);
        if (b == acs_pkg::ESC_CHAR)
            scan_state = SCAN_ESC;
        else
            put_out(b);
    endfunction

    // advance the model by one accepted beat, queue what it owes
    function automatic void strip_predict(input logic [7:0] b, input logic last);
        out_beat_t tail;
        beat_out.delete();
        case (scan_state)
            SCAN_ESC:
            begin
                if (b == acs_pkg::LBRACKET)
                begin
                    scan_state = SCAN_CSI;
                    held_cnt   = 0;
                end
                else
                begin
                    replay_held();
                    take_plain(b);
                end
            end
            SCAN_CSI:
            begin
                case (classify(b))
                    CLS_PARAM:
                    begin
                        if (held_cnt < acs_pkg::PARAM_DEPTH)
                        begin
                            held_buf[held_cnt] = b;
                            held_cnt++;
                        end
                        else
                        begin
                            // store full: whole sequence goes out, byte too
                            store_overflows++;
                            replay_held();
                            put_out(b);
                        end
                    end
                    CLS_FINAL:
                    begin
                        csi_stripped++;
                        scan_state = SCAN_IDLE;
                        held_cnt   = 0;
                    end
                    default:
                    begin
                        replay_held();
                        take_plain(b);
                    end
                endcase
            end
            default:
            begin
                scan_state = SCAN_IDLE;
                take_plain(b);
            end
        endcase

        if (last)
        begin
            replay_held();
            // nothing left to say: an empty marker closes the text
            if (beat_out.size() == 0)
                beat_out.push_back('0);
            tail = beat_out.pop_back();
            tail.text_end = 1'b1;
            beat_out.push_back(tail);
        end
        if (beat_out.size() > 0)
        begin
            tail = beat_out.pop_back();
            tail.run_last = 1'b1;
            beat_out.push_back(tail);
        end
        foreach (beat_out[i])
            pending_out_q.push_back(beat_out[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // called right after a rising edge; returns after an edge at which s_tready reads high
    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        strip_predict(b, last);
        beats_sent++;
    endtask

    task automatic send_run(input logic [7:0] bytes[$], input logic end_text);
        foreach (bytes[i])
            send_beat(bytes[i], end_text && (i == bytes.size() - 1));
    endtask

    function automatic logic [7:0] rand_param_byte();
        if ($urandom_range(0, 10) == 0)
            return acs_pkg::SEMICOLON;
        return acs_pkg::DIGIT_LO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_final_byte();
        if ($urandom_range(0, 1) == 0)
            return acs_pkg::UPPER_LO + 8'($urandom_range(0, 25));
        return acs_pkg::LOWER_LO + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_other_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (classify(b) != CLS_OTHER)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // a text sometimes ends mid-sequence
    function automatic logic rand_last();
        return ($urandom_range(0, 39) == 0);
    endfunction

    function automatic int rand_param_len();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, acs_pkg::PARAM_DEPTH);
        return $urandom_range(0, 4);
    endfunction

    // one well-formed or deliberately broken chunk with random content
    task automatic send_chunk();
        chunk_t     kind;
        int         n;
        int         r;
        logic       end_here;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        if (r < 4)
            kind = CHUNK_CSI;
        else if (r == 4)
            kind = CHUNK_ABORT;
        else if (r == 5)
            kind = CHUNK_LONE_ESC;
        else if (r == 6)
            kind = CHUNK_OVERFLOW;
        else
            kind = CHUNK_PLAIN;
        end_here = ($urandom_range(0, 7) == 0);

        case (kind)
            CHUNK_CSI, CHUNK_ABORT, CHUNK_OVERFLOW:
            begin
                n = (kind == CHUNK_OVERFLOW)
                    ? acs_pkg::PARAM_DEPTH + 1 + $urandom_range(0, 2)
                    : rand_param_len();
                send_beat(acs_pkg::ESC_CHAR, rand_last());
                send_beat(acs_pkg::LBRACKET, rand_last());
                for (int k = 0; k < n; k++)
                    send_beat(rand_param_byte(), rand_last());
                b = (kind == CHUNK_ABORT) ? rand_other_byte() : rand_final_byte();
                send_beat(b, end_here);
            end
            CHUNK_LONE_ESC:
            begin
                send_beat(acs_pkg::ESC_CHAR, rand_last());
                b = 8'($urandom_range(0, 255));
                while (b == acs_pkg::LBRACKET)
                    b = 8'($urandom_range(0, 255));
                send_beat(b, end_here);
            end
            default:
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_beat(8'($urandom_range(0, 255)), (k == n - 1) && end_here);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sink side: random stalls, mostly short, some long
    // ------------------------------------------------------------------------
    initial
    begin : sink_drive
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_steady)
            begin
                m_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each taken output beat against the oldest owed result
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            out_beat_t want;
            if (pending_out_q.size() == 0)
            begin
                mismatches++;
                $display("[%0t] unexpected beat: expected none, actual data %02h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_out_q.pop_front();
                check_field("out_byte", want.out_byte, m_tdata);
                check_field("has_byte", want.has_byte, m_tuser[0]);
                check_field("run_last", want.run_last, m_tlast);
                check_field("text_end", want.text_end, m_tuser[1]);
                results_seen++;
                if (want.text_end)
                    texts_closed++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[%0t] timeout: %0d results still owed", $time, pending_out_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // byte extremes, complete and aborted sequences, lone ESC, end of text
    task automatic test_directed_cases();
        logic [7:0] q[$];
        q = {8'h00, 8'hff, acs_pkg::UPPER_LO};              // plain, letter while idle
        send_run(q, 1'b0);
        q = {acs_pkg::ESC_CHAR, acs_pkg::LBRACKET, acs_pkg::DIGIT_LO,
             acs_pkg::SEMICOLON, acs_pkg::DIGIT_HI, acs_pkg::LOWER_HI};
        send_run(q, 1'b0);                                  // stripped
        q = {acs_pkg::ESC_CHAR, 8'h51};                     // lone ESC then 'Q'
        send_run(q, 1'b0);
        q = {acs_pkg::ESC_CHAR, acs_pkg::ESC_CHAR, acs_pkg::LBRACKET,
             acs_pkg::UPPER_HI};                            // ESC restarts, then stripped
        send_run(q, 1'b0);
        q = {acs_pkg::ESC_CHAR, acs_pkg::LBRACKET, 8'h31, 8'h40};  // '@' aborts, replayed
        send_run(q, 1'b0);
        q = {acs_pkg::ESC_CHAR, acs_pkg::LBRACKET, 8'h34};  // text ends while held
        send_run(q, 1'b1);
        q = {acs_pkg::ESC_CHAR, acs_pkg::LBRACKET, acs_pkg::LOWER_LO};  // empty marker
        send_run(q, 1'b1);
    endtask

    task automatic test_noise_text(input int count);
        for (int k = 0; k < count; k++)
            send_beat(8'($urandom_range(0, 255)), rand_last());
    endtask

    task automatic test_csi_traffic(input int count);
        int stop_at;
        stop_at = beats_sent + count;
        send_chunk();
        while (beats_sent < stop_at)
            send_chunk();
    endtask

    // no gaps at the source; first with a free sink, then with a stalling one
    task automatic test_back_to_back(input int count);
        int stop_at;
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        stop_at = beats_sent + count / 2;
        while (beats_sent < stop_at)
            send_chunk();
        sink_steady = 1'b0;
        stop_at = beats_sent + count / 2;
        while (beats_sent < stop_at)
            send_chunk();
        src_steady = 1'b0;
    endtask

    initial
    begin : main_seq
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_noise_text(60);
        test_csi_traffic(150);
        test_back_to_back(50);
        s_tvalid <= 1'b0;

        while (pending_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats and %0d output beats in %0d texts.",
                 beats_sent, results_seen, texts_closed);
        $display("Sequences stripped: %0d, parameter store overflows: %0d.",
                 csi_stripped, store_overflows);
        if (mismatches == 0 && pending_out_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
